// File: design/dds_command_serializer_assert.svh
// Assertion macros shared by the serializer modules.
`ifndef DDS_COMMAND_SERIALIZER_ASSERT_SVH
`define DDS_COMMAND_SERIALIZER_ASSERT_SVH

// Condition holds at every clock edge outside reset.
`define DCS_ASSERT_HOLDS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("dcs assertion failed");

// Same-cycle implication.
`define DCS_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dcs assertion failed");

// Next-cycle implication.
`define DCS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dcs assertion failed");

`endif

// File: design/dcs_pkg.sv
// Types and constants of the DDS command serializer.
package dcs_pkg;

  typedef enum logic [1:0] {
    KIND_FREQ  = 2'd0,
    KIND_AMP   = 2'd1,
    KIND_PHASE = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  localparam int unsigned PLAN_BYTES = 7;
  localparam int unsigned IDX_W      = $clog2(PLAN_BYTES);

  typedef struct packed {
    logic [PLAN_BYTES-1:0][7:0] bytes;
    logic [IDX_W-1:0]           nbytes;
  } plan_t;

  localparam logic [7:0] ADDR_CSR = 8'h00;
  localparam logic [7:0] ADDR_FTW = 8'h04;
  localparam logic [7:0] ADDR_POW = 8'h05;
  localparam logic [7:0] ADDR_ACR = 8'h06;
  localparam logic [7:0] CSR_CH0  = 8'h10;

  localparam logic [IDX_W-1:0] NBYTES_FREQ  = IDX_W'(7);
  localparam logic [IDX_W-1:0] NBYTES_AMP   = IDX_W'(6);
  localparam logic [IDX_W-1:0] NBYTES_PHASE = IDX_W'(5);
  localparam logic [IDX_W-1:0] IDX_CSR_END  = IDX_W'(1);

  localparam int unsigned NUM_CHANNELS = 4;

  localparam logic [28:0] FREQ_MAX   = 29'd499999999;
  localparam logic [28:0] AMP_MAX    = 29'd1023;
  localparam logic [28:0] PHASE_MAX  = 29'd359;
  localparam logic [15:0] AMP_ENABLE = 16'h1000;

  // Tuning word = floor(f * 2^32 / 500e6) = floor(f * 2^24 / 1953125),
  // done as floor(f * ceil(2^74 / 1953125) / 2^50), exact for f < 2^29.
  localparam logic [127:0] SYS_CLOCK_HZ = 128'd500000000;
  localparam logic [127:0] FTW_DIV      = SYS_CLOCK_HZ / 128'd256;
  localparam int unsigned  FTW_SHIFT    = 50;
  localparam logic [127:0] FTW_RECIP_WIDE =
    ((128'd1 << (FTW_SHIFT + 24)) + FTW_DIV - 128'd1) / FTW_DIV;
  localparam logic [53:0]  FTW_RECIP    = FTW_RECIP_WIDE[53:0];
  localparam logic [26:0]  FTW_RECIP_LO = FTW_RECIP[26:0];
  localparam logic [26:0]  FTW_RECIP_HI = FTW_RECIP[53:27];

  // Phase word = floor(deg * 16384 / 360) = floor(deg * 2048 / 45).
  localparam int unsigned PHASE_FULL  = 16384;
  localparam int unsigned DEG_FULL    = 360;
  localparam int unsigned PH_GCD      = 8;
  localparam int unsigned PH_NUM      = PHASE_FULL / PH_GCD;
  localparam int unsigned PH_DEN      = DEG_FULL / PH_GCD;
  localparam int unsigned PH_NUM_LOG2 = $clog2(PH_NUM);
  localparam int unsigned PH_SHIFT    = 26;
  localparam logic [20:0] PH_RECIP    =
    21'(((32'd1 << PH_SHIFT) + PH_DEN - 32'd1) / PH_DEN);

  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

endpackage

// File: design/dcs_cmd_if.sv
// Command channel: kind, channel and value with valid/ready.
interface dcs_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [2:0]  channel;
  logic [28:0] value;

  modport source (output valid, kind, channel, value, input ready);
  modport sink (input valid, kind, channel, value, output ready);
endinterface

// File: design/dcs_byte_if.sv
// Byte channel: serial bytes with framing flags and valid/ready.
interface dcs_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] serial_byte;
  logic       frame_end;
  logic       pulse_update;
  logic       last;

  modport source (output valid, serial_byte, frame_end, pulse_update, last, input ready);
  modport sink (input valid, serial_byte, frame_end, pulse_update, last, output ready);
endinterface

// File: design/dds_command_serializer.sv
// A taken command is registered in the scaling stage, written to the plan queue, then
// loaded byte by byte into the output register. Throughput: one byte per cycle from the
// back end while tx.ready is high; frequency, amplitude and phase commands are 7, 6 and 5
// bytes. A two-entry plan queue and a one-stage scaling pipeline let the front run ahead.
// Commands on channels above 3 or of kind 3 are taken and dropped.
// Reset: synchronous; clears only s1_valid, queue pointers, count, idx and out_valid.
module dds_command_serializer (
  input  logic        clk,
  input  logic        rst,
  dcs_cmd_if.sink     cmd,
  dcs_byte_if.source  tx
);

  logic           push_valid;
  logic           push_ready;
  dcs_pkg::plan_t push_data;
  logic           head_valid;
  logic           pop;
  dcs_pkg::plan_t head;

  dcs_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  dcs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (head_valid),
    .pop        (pop),
    .pop_data   (head)
  );

  dcs_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .tx         (tx)
  );

endmodule

// File: design/dcs_front.sv
// Front end: takes commands, saturates, scales and builds the byte plan.
module dcs_front (
  input  logic            clk,
  input  logic            rst,
  dcs_cmd_if.sink         cmd,
  output logic            push_valid,
  input  logic            push_ready,
  output dcs_pkg::plan_t  push_data
);

  logic                  s1_valid;
  logic                  s1_valid_next;
  dcs_pkg::kind_t        s1_kind;
  logic [1:0]            s1_channel;
  logic [55:0]           s1_plo;
  logic [55:0]           s1_phi;
  logic [15:0]           s1_word;

  dcs_pkg::kind_t        in_kind;
  logic                  legal;
  logic                  take;
  logic [28:0]           fv;
  logic [9:0]            av;
  logic [8:0]            pv;
  logic [19:0]           ph_x;
  logic [40:0]           ph_prod;
  logic [15:0]           amp_word;
  logic [15:0]           ph_word;
  logic [82:0]           ftw_sum;
  logic [31:0]           ftw;

  assign in_kind   = dcs_pkg::kind_t'(cmd.kind);
  assign legal     = (32'(cmd.channel) < dcs_pkg::NUM_CHANNELS) &&
                     (in_kind != dcs_pkg::KIND_NONE);
  assign cmd.ready = !s1_valid || push_ready;
  assign take      = cmd.valid && cmd.ready;

  always_comb begin
    fv = (cmd.value > dcs_pkg::FREQ_MAX) ? dcs_pkg::FREQ_MAX : cmd.value;
    av = (cmd.value > dcs_pkg::AMP_MAX) ? dcs_pkg::AMP_MAX[9:0] : cmd.value[9:0];
    pv = (cmd.value > dcs_pkg::PHASE_MAX) ? dcs_pkg::PHASE_MAX[8:0] : cmd.value[8:0];
    ph_x     = 20'(pv) << dcs_pkg::PH_NUM_LOG2;
    ph_prod  = 41'(ph_x) * 41'(dcs_pkg::PH_RECIP);
    amp_word = 16'(av) | dcs_pkg::AMP_ENABLE;
    ph_word  = {2'b00, ph_prod[dcs_pkg::PH_SHIFT +: 14]};
  end

  always_comb begin
    s1_valid_next = s1_valid && !push_ready;
    if (take) begin
      s1_valid_next = legal;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= s1_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_kind    <= in_kind;
      s1_channel <= cmd.channel[1:0];
      s1_plo     <= 56'(fv) * 56'(dcs_pkg::FTW_RECIP_LO);
      s1_phi     <= 56'(fv) * 56'(dcs_pkg::FTW_RECIP_HI);
      s1_word    <= (in_kind == dcs_pkg::KIND_AMP) ? amp_word : ph_word;
    end
  end

  assign ftw_sum = {s1_phi, 27'd0} + 83'(s1_plo);
  assign ftw     = ftw_sum[dcs_pkg::FTW_SHIFT +: 32];

  always_comb begin
    push_data.bytes    = '0;
    push_data.bytes[0] = dcs_pkg::ADDR_CSR;
    push_data.bytes[1] = dcs_pkg::CSR_CH0 << s1_channel;
    unique case (s1_kind)
      dcs_pkg::KIND_FREQ: begin
        push_data.bytes[2] = dcs_pkg::ADDR_FTW;
        push_data.bytes[3] = ftw[31:24];
        push_data.bytes[4] = ftw[23:16];
        push_data.bytes[5] = ftw[15:8];
        push_data.bytes[6] = ftw[7:0];
        push_data.nbytes   = dcs_pkg::NBYTES_FREQ;
      end
      dcs_pkg::KIND_AMP: begin
        push_data.bytes[2] = dcs_pkg::ADDR_ACR;
        push_data.bytes[3] = 8'h00;
        push_data.bytes[4] = s1_word[15:8];
        push_data.bytes[5] = s1_word[7:0];
        push_data.nbytes   = dcs_pkg::NBYTES_AMP;
      end
      default: begin
        push_data.bytes[2] = dcs_pkg::ADDR_POW;
        push_data.bytes[3] = s1_word[15:8];
        push_data.bytes[4] = s1_word[7:0];
        push_data.nbytes   = dcs_pkg::NBYTES_PHASE;
      end
    endcase
  end

  assign push_valid = s1_valid;

endmodule

// File: design/dcs_queue.sv
// Two-entry plan queue between front and back ends.
`include "dds_command_serializer_assert.svh"

module dcs_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push_valid,
  output logic                   push_ready,
  input  dcs_pkg::plan_t         push_data,
  output logic                   pop_valid,
  input  logic                   pop,
  output dcs_pkg::plan_t         pop_data
);

  dcs_pkg::plan_t                  mem [dcs_pkg::Q_DEPTH];
  logic [dcs_pkg::Q_PTR_W-1:0]     wr_ptr;
  logic [dcs_pkg::Q_PTR_W-1:0]     rd_ptr;
  logic [dcs_pkg::Q_CNT_W-1:0]     count;
  logic                            push;

  assign push_ready = (32'(count) < dcs_pkg::Q_DEPTH);
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  `DCS_ASSERT_HOLDS(a_count_bound, 32'(count) <= dcs_pkg::Q_DEPTH)
  `DCS_ASSERT_IMPLIES(a_no_pop_empty, pop, pop_valid)
  `DCS_ASSERT_NEXT(a_fill, push && !pop && count == 2'd1, count == 2'd2)

endmodule

// File: design/dcs_back.sv
// Back end: walks head plan, emits a byte per cycle if ready.
`include "dds_command_serializer_assert.svh"

module dcs_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             head_valid,
  input  dcs_pkg::plan_t   head,
  output logic             pop,
  dcs_byte_if.source       tx
);

  logic [dcs_pkg::IDX_W-1:0] idx;
  logic                      out_valid;
  logic [7:0]                out_byte;
  logic                      out_fend;
  logic                      out_upd;
  logic                      out_last;
  logic                      adv;
  logic                      load;
  logic                      is_last;

  assign adv     = !out_valid || tx.ready;
  assign load    = adv && head_valid;
  assign is_last = (idx == head.nbytes - 1'b1);
  assign pop     = load && is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (adv) begin
        out_valid <= head_valid;
      end
      if (load) begin
        idx <= is_last ? '0 : idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte <= head.bytes[idx];
      out_fend <= is_last || (idx == dcs_pkg::IDX_CSR_END);
      out_upd  <= is_last;
      out_last <= is_last;
    end
  end

  assign tx.valid        = out_valid;
  assign tx.serial_byte  = out_byte;
  assign tx.frame_end    = out_fend;
  assign tx.pulse_update = out_upd;
  assign tx.last         = out_last;

  `DCS_ASSERT_IMPLIES(a_idx_bound, head_valid, idx < head.nbytes)
  `DCS_ASSERT_IMPLIES(a_last_flags, out_valid && out_last, out_fend && out_upd)
  `DCS_ASSERT_IMPLIES(a_csr_byte, out_valid && out_fend && !out_last,
                      $onehot(out_byte[7:4]) && out_byte[3:0] == 4'h0)

endmodule

// File: test/dds_command_serializer_tb.sv
// Self-checking testbench for the DDS command serializer: directed table, then random commands.
module dds_command_serializer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned RX_HOLD_CYCLES = 300;
  localparam int unsigned PHASE_ITEMS    = 116;
  localparam int unsigned MAX_PRINTED    = 50;
  localparam logic [63:0] SYS_CLK_HZ     = 64'd500000000;
  localparam int unsigned AMP_LIM        = 1023;
  localparam int unsigned PHASE_LIM      = 359;
  localparam int unsigned FREQ_LIM       = 499999999;

  typedef struct packed {
    logic [7:0] serial_byte;
    logic       frame_end;
    logic       pulse_update;
    logic       last;
  } tx_byte_t;

  // Byte sequence is left-aligned: first byte in bits 55:48.
  typedef struct {
    dcs_pkg::kind_t kind;
    logic [2:0]     channel;
    logic [28:0]    value;
    bit             typed;
    int unsigned    nbytes;
    logic [55:0]    seq;
  } cmd_row_t;

  localparam int unsigned NUM_ROWS = 22;

  cmd_row_t cmd_rows [NUM_ROWS] = '{
    '{dcs_pkg::KIND_FREQ,  3'd0, 29'd0,         1'b1, 7, 56'h00_10_04_00_00_00_00},
    '{dcs_pkg::KIND_FREQ,  3'd3, 29'd499999999, 1'b1, 7, 56'h00_80_04_FF_FF_FF_F7},
    '{dcs_pkg::KIND_FREQ,  3'd1, 29'h1FFFFFFF,  1'b1, 7, 56'h00_20_04_FF_FF_FF_F7},
    '{dcs_pkg::KIND_FREQ,  3'd2, 29'd1,         1'b0, 0, 56'h0},
    '{dcs_pkg::KIND_FREQ,  3'd0, 29'd100000000, 1'b0, 0, 56'h0},
    '{dcs_pkg::KIND_FREQ,  3'd3, 29'h15555555,  1'b0, 0, 56'h0},
    '{dcs_pkg::KIND_FREQ,  3'd2, 29'h0AAAAAAA,  1'b0, 0, 56'h0},
    '{dcs_pkg::KIND_AMP,   3'd0, 29'd0,         1'b1, 6, 56'h00_10_06_00_10_00_00},
    '{dcs_pkg::KIND_AMP,   3'd1, 29'd1023,      1'b1, 6, 56'h00_20_06_00_13_FF_00},
    '{dcs_pkg::KIND_AMP,   3'd2, 29'd1024,      1'b1, 6, 56'h00_40_06_00_13_FF_00},
    '{dcs_pkg::KIND_AMP,   3'd3, 29'h1FFFFFFF,  1'b1, 6, 56'h00_80_06_00_13_FF_00},
    '{dcs_pkg::KIND_AMP,   3'd0, 29'd512,       1'b0, 0, 56'h0},
    '{dcs_pkg::KIND_PHASE, 3'd0, 29'd0,         1'b1, 5, 56'h00_10_05_00_00_00_00},
    '{dcs_pkg::KIND_PHASE, 3'd1, 29'd359,       1'b1, 5, 56'h00_20_05_3F_D2_00_00},
    '{dcs_pkg::KIND_PHASE, 3'd2, 29'd360,       1'b1, 5, 56'h00_40_05_3F_D2_00_00},
    '{dcs_pkg::KIND_PHASE, 3'd3, 29'h1FFFFFFF,  1'b1, 5, 56'h00_80_05_3F_D2_00_00},
    '{dcs_pkg::KIND_PHASE, 3'd0, 29'd90,        1'b0, 0, 56'h0},
    '{dcs_pkg::KIND_PHASE, 3'd1, 29'd180,       1'b0, 0, 56'h0},
    '{dcs_pkg::KIND_FREQ,  3'd4, 29'd1000,      1'b1, 0, 56'h0},
    '{dcs_pkg::KIND_AMP,   3'd7, 29'd5,         1'b1, 0, 56'h0},
    '{dcs_pkg::KIND_NONE,  3'd0, 29'd7,         1'b1, 0, 56'h0},
    '{dcs_pkg::KIND_NONE,  3'd7, 29'h1FFFFFFF,  1'b1, 0, 56'h0}
  };

  logic clk;
  logic rst;

  dcs_cmd_if  cmd_bus ();
  dcs_byte_if tx_bus ();

  dds_command_serializer u_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_bus),
    .tx  (tx_bus)
  );

  tx_byte_t    expected_bytes [$];
  int unsigned mismatches;
  int unsigned bytes_seen;
  int unsigned quiet_cycles;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  logic        hold_go;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Serial bytes for one command; returns the byte count (0 when dropped).
  function automatic int unsigned encode_cmd(input dcs_pkg::kind_t k, input logic [2:0] ch,
                                             input logic [28:0] v, output logic [55:0] seq);
    logic [28:0] sat;
    logic [63:0] tuning;
    logic [15:0] word;
    logic [7:0]  sel;
    seq = '0;
    if (ch > 3'd3 || k == dcs_pkg::KIND_NONE) return 0;
    sel = dcs_pkg::CSR_CH0 << ch;
    case (k)
      dcs_pkg::KIND_FREQ: begin
        sat = (v > dcs_pkg::FREQ_MAX) ? dcs_pkg::FREQ_MAX : v;
        tuning = ({35'd0, sat} << 32) / SYS_CLK_HZ;
        seq = {dcs_pkg::ADDR_CSR, sel, dcs_pkg::ADDR_FTW, tuning[31:0]};
        return 7;
      end
      dcs_pkg::KIND_AMP: begin
        sat = (v > dcs_pkg::AMP_MAX) ? dcs_pkg::AMP_MAX : v;
        word = sat[15:0] | dcs_pkg::AMP_ENABLE;
        seq = {dcs_pkg::ADDR_CSR, sel, dcs_pkg::ADDR_ACR, 8'h00, word, 8'h00};
        return 6;
      end
      default: begin
        sat = (v > dcs_pkg::PHASE_MAX) ? dcs_pkg::PHASE_MAX : v;
        word = 16'(({3'd0, sat} * 32'd16384) / 32'd360);
        seq = {dcs_pkg::ADDR_CSR, sel, dcs_pkg::ADDR_POW, word, 16'h0000};
        return 5;
      end
    endcase
  endfunction

  // Channel-select frame ends at byte 1, register frame at the last byte.
  function automatic void queue_frames(input logic [55:0] seq, input int unsigned n);
    tx_byte_t e;
    for (int i = 0; i < n; i++) begin
      e.serial_byte  = seq[55 - 8*i -: 8];
      e.frame_end    = (i == 1) || (i == n - 1);
      e.pulse_update = (i == n - 1);
      e.last         = (i == n - 1);
      expected_bytes.push_back(e);
    end
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatches < MAX_PRINTED) $display("%0t ns: mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("byte %0d %s got %h want %h", bytes_seen, name, got, want));
  endtask

  task automatic send_cmd(input dcs_pkg::kind_t k, input logic [2:0] ch,
                          input logic [28:0] v, input bit typed,
                          input logic [55:0] tseq, input int unsigned tn);
    logic [55:0] seq;
    int unsigned n;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      cmd_bus.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_bus.valid   <= 1'b1;
    cmd_bus.kind    <= k;
    cmd_bus.channel <= ch;
    cmd_bus.value   <= v;
    @(posedge clk);
    while (!cmd_bus.ready) @(posedge clk);
    if (typed) begin
      queue_frames(tseq, tn);
    end else begin
      n = encode_cmd(k, ch, v, seq);
      queue_frames(seq, n);
    end
  endtask

  task automatic run_random(input int unsigned count);
    int unsigned    sent;
    int unsigned    lim;
    dcs_pkg::kind_t k;
    logic [2:0]     ch;
    logic [28:0]    v;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(99) < 8) begin
        // dropped command: bad channel or kind three
        k  = dcs_pkg::kind_t'($urandom_range(3));
        ch = 3'($urandom_range(7));
        v  = 29'($urandom);
        if (k != dcs_pkg::KIND_NONE) ch = ch | 3'b100;
        send_cmd(k, ch, v, 1'b0, '0, 0);
      end else begin
        k   = dcs_pkg::kind_t'($urandom_range(2));
        ch  = 3'($urandom_range(3));
        lim = (k == dcs_pkg::KIND_FREQ) ? FREQ_LIM :
              (k == dcs_pkg::KIND_AMP) ? AMP_LIM : PHASE_LIM;
        case ($urandom_range(9))
          0, 1:    v = 29'($urandom);
          2:       v = 29'($urandom_range(lim + 2, lim - 2));
          3:       v = 29'($urandom_range(15));
          default: v = 29'($urandom_range(lim));
        endcase
        send_cmd(k, ch, v, 1'b0, '0, 0);
      end
      sent++;
    end
  endtask

  // Receiver: random ready, plus one long hold-off on request.
  initial begin
    int unsigned hold_left;
    bit          hold_done;
    tx_bus.ready = 1'b0;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go && !hold_done) begin
        hold_done = 1'b1;
        hold_left = RX_HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        tx_bus.ready <= 1'b0;
      end else begin
        tx_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Byte checker and watchdog.
  always @(posedge clk) begin
    tx_byte_t want;
    if (!rst && tx_bus.valid && tx_bus.ready) begin
      if (expected_bytes.size() == 0) begin
        report_mismatch($sformatf("byte %0d unexpected: %h", bytes_seen, tx_bus.serial_byte));
      end else begin
        want = expected_bytes.pop_front();
        check_field("serial_byte", tx_bus.serial_byte, want.serial_byte);
        check_field("frame_end", 8'(tx_bus.frame_end), 8'(want.frame_end));
        check_field("pulse_update", 8'(tx_bus.pulse_update), 8'(want.pulse_update));
        check_field("last", 8'(tx_bus.last), 8'(want.last));
      end
      bytes_seen++;
    end
    if ((cmd_bus.valid && cmd_bus.ready) || (tx_bus.valid && tx_bus.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    rst             = 1'b1;
    cmd_bus.valid   = 1'b0;
    cmd_bus.kind    = dcs_pkg::KIND_FREQ;
    cmd_bus.channel = 3'd0;
    cmd_bus.value   = 29'd0;
    hold_go         = 1'b0;
    mismatches      = 0;
    bytes_seen      = 0;
    quiet_cycles    = 0;
    send_idle_pct   = 12;
    recv_idle_pct   = 45;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < NUM_ROWS; r++)
      send_cmd(cmd_rows[r].kind, cmd_rows[r].channel, cmd_rows[r].value,
               cmd_rows[r].typed, cmd_rows[r].seq, cmd_rows[r].nbytes);

    // long receiver stall while commands keep coming
    hold_go <= 1'b1;
    run_random(PHASE_ITEMS);

    send_idle_pct <= 45;
    recv_idle_pct <= 12;
    run_random(PHASE_ITEMS);

    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    run_random(PHASE_ITEMS);

    cmd_bus.valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
